// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table package
// Shared sizes, operation and status codes, and the structures that pass
// between the sequencer and the entry store.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned MAX_SCOPES  = 16;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LVL_W   = $clog2(MAX_SCOPES);
  localparam int unsigned DEPTH_W = $clog2(MAX_SCOPES + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_OPEN     = 3'd0,
    FN_CLOSE    = 3'd1,
    FN_ADD      = 3'd2,
    FN_LOOK_IN  = 3'd3,
    FN_LOOK_ALL = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SCOPE   = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_STACK_FULL = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
  } st_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } st_rsp_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [LVL_W-1:0]   scope_level;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   found_tag;
    logic [DEPTH_W-1:0] depth_now;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sst_if.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table channels
// Request and response channels, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_req_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [TAG_W-1:0]  entry_tag;

  modport source (output valid, output func, output key, output entry_tag, input ready);
  modport sink   (input valid, input func, input key, input entry_tag, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [LVL_W-1:0]   scope_level;
  logic [SLOT_W-1:0]  slot;
  logic [TAG_W-1:0]   found_tag;
  logic [DEPTH_W-1:0] depth_now;

  modport source (output valid, output status, output found, output scope_level,
                  output slot, output found_tag, output depth_now, input ready);
  modport sink   (input valid, input status, input found, input scope_level,
                  input slot, input found_tag, input depth_now, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sst_store.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table entry store
// Key and tag memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_store import sst_pkg::*; (
  input  wire logic    clk_i,
  input  wire st_req_t req_i,
  output st_rsp_t      rsp_o
);

  st_rsp_t mem_q [MAX_ENTRIES];
  st_rsp_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= '{key: req_i.key, tag: req_i.tag};
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  assign rsp_o = rd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table sequencer
// Holds the scope stack and entry count, runs operations; lookups walk the
// store one entry per cycle, except on scope steps, via one key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl import sst_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sst_req_if.sink      req_i,
  sst_rsp_if.source    rsp_o,
  output st_req_t      st_req_o,
  input  wire st_rsp_t st_rsp_i
);

  state_e state_q, state_d;

  logic [FUNC_W-1:0]  func_q;
  logic [KEY_W-1:0]   key_q;
  logic [TAG_W-1:0]   tag_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0]   start_q [MAX_SCOPES];
  logic               start_we;
  logic [LVL_W-1:0]   start_wa;

  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               cmp_vld_q;
  logic [SLOT_W-1:0]  cmp_slot_q;
  logic [LVL_W-1:0]   cmp_lvl_q;

  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  hit_slot_q, hit_slot_d;
  logic [LVL_W-1:0]   hit_lvl_q, hit_lvl_d;
  logic [TAG_W-1:0]   hit_tag_q, hit_tag_d;
  logic [STAT_W-1:0]  stat_q, stat_d;

  res_t               out_q, out_d;
  logic               out_vld_q, out_vld_d;

  logic [DEPTH_W-1:0] depth_m1;
  logic [LVL_W-1:0]   start_ra;
  logic [CNT_W-1:0]   start_rd;
  logic [CNT_W-1:0]   slot_nx;
  logic               scan_end;
  logic               below;
  logic               out_free;
  logic               accept;
  logic               no_scope;
  logic               cmp_hit;

  assign depth_m1 = depth_q - DEPTH_W'(1);
  assign start_ra = (state_q == S_SCAN) ? lvl_q : depth_m1[LVL_W-1:0];
  assign start_rd = start_q[start_ra];
  assign slot_nx  = idx_q - CNT_W'(1);
  assign scan_end = (idx_q == '0);
  assign below    = (slot_nx < start_rd);
  assign out_free = !out_vld_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign no_scope = (depth_q == '0);
  assign cmp_hit  = cmp_vld_q && (st_rsp_i.key == key_q) &&
                    (!hit_q || (hit_lvl_q == cmp_lvl_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((func_q == FN_LOOK_IN || func_q == FN_LOOK_ALL) && !no_scope) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_end || (below && func_q == FN_LOOK_IN)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    depth_d    = depth_q;
    start_we   = 1'b0;
    start_wa   = depth_q[LVL_W-1:0];
    idx_d      = idx_q;
    lvl_d      = lvl_q;
    hit_d      = hit_q;
    hit_slot_d = hit_slot_q;
    hit_lvl_d  = hit_lvl_q;
    hit_tag_d  = hit_tag_q;
    stat_d     = stat_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    st_req_o   = '{we: 1'b0, re: 1'b0, addr: cnt_q[SLOT_W-1:0], key: key_q, tag: tag_q};

    if (cmp_hit) begin
      hit_d      = 1'b1;
      hit_slot_d = cmp_slot_q;
      hit_lvl_d  = cmp_lvl_q;
      hit_tag_d  = st_rsp_i.tag;
    end

    case (state_q)
      S_EXEC: begin
        hit_d      = 1'b0;
        hit_slot_d = '0;
        hit_lvl_d  = '0;
        hit_tag_d  = '0;
        stat_d     = STAT_OK;
        idx_d      = cnt_q;
        lvl_d      = depth_m1[LVL_W-1:0];
        case (func_e'(func_q))
          FN_OPEN: begin
            if (depth_q == DEPTH_W'(MAX_SCOPES)) begin
              stat_d = STAT_STACK_FULL;
            end else begin
              start_we = 1'b1;
              depth_d  = depth_q + DEPTH_W'(1);
            end
          end
          FN_CLOSE: begin
            if (no_scope) begin
              stat_d = STAT_NO_SCOPE;
            end else begin
              depth_d = depth_m1;
              cnt_d   = start_rd;
            end
          end
          FN_ADD: begin
            if (no_scope) begin
              stat_d = STAT_NO_SCOPE;
            end else if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
              stat_d = STAT_FULL;
            end else begin
              st_req_o.we = 1'b1;
              hit_slot_d  = cnt_q[SLOT_W-1:0];
              hit_lvl_d   = depth_m1[LVL_W-1:0];
              cnt_d       = cnt_q + CNT_W'(1);
            end
          end
          FN_LOOK_IN, FN_LOOK_ALL: begin
            if (no_scope) begin
              stat_d = STAT_NO_SCOPE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (!scan_end) begin
          if (below) begin
            if (func_q != FN_LOOK_IN) begin
              lvl_d = lvl_q - LVL_W'(1);
            end
          end else begin
            st_req_o.re   = 1'b1;
            st_req_o.addr = slot_nx[SLOT_W-1:0];
            idx_d         = slot_nx;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '{status: stat_q, found: hit_q, scope_level: hit_lvl_q,
                        slot: hit_slot_q, found_tag: hit_tag_q, depth_now: depth_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      depth_q   <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      depth_q   <= depth_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= st_req_o.re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      key_q  <= req_i.key;
      tag_q  <= req_i.entry_tag;
    end
    if (start_we) begin
      start_q[start_wa] <= cnt_q;
    end
    idx_q      <= idx_d;
    lvl_q      <= lvl_d;
    cmp_slot_q <= st_req_o.addr;
    cmp_lvl_q  <= lvl_q;
    hit_q      <= hit_d;
    hit_slot_q <= hit_slot_d;
    hit_lvl_q  <= hit_lvl_d;
    hit_tag_q  <= hit_tag_d;
    stat_q     <= stat_d;
    out_q      <= out_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.found       = out_q.found;
  assign rsp_o.scope_level = out_q.scope_level;
  assign rsp_o.slot        = out_q.slot;
  assign rsp_o.found_tag   = out_q.found_tag;
  assign rsp_o.depth_now   = out_q.depth_now;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond store size");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_SCOPES))
    else $error("scope depth beyond stack size");

  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req_o.we |-> (state_q == S_EXEC && cnt_q < CNT_W'(MAX_ENTRIES)))
    else $error("store write outside an add");

  a_scan_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> $stable(depth_q) && $stable(cnt_q))
    else $error("scope state changed during a lookup");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.found) |-> out_q.status == STAT_OK)
    else $error("match reported with an error status");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/scoped_symbol_table.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table
// Stack of nested scopes over one shared key and tag store.
// ----------------------------------------------------------------------------
// Requests arrive on req_i as valid/ready beats carrying func, key and
// entry_tag; each request yields exactly one response beat on rsp_o.
// The block takes one request at a time: req_i.ready is high only while
// the sequencer is idle, which includes while a finished response still
// waits in the output register for rsp_o.ready.
// Open, close, add, unused codes and a lookup with no open scope pass
// from the execute state straight to the response state and then to the
// output register. A lookup runs the scan state in between, with the
// single key comparator reading one store entry per cycle except when it
// steps out to an enclosing scope, and then a drain state for the last
// comparison.
// Reset clears the entry count, the scope depth and all handshake state;
// the store itself is not cleared and is only read where written.
// A stalled receiver holds the response beat; the block then finishes the
// next request and waits with it until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module scoped_symbol_table import sst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sst_req_if.sink   req_i,
  sst_rsp_if.source rsp_o
);

  st_req_t st_req;
  st_rsp_t st_rsp;

  sst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .st_req_o (st_req),
    .st_rsp_i (st_rsp)
  );

  sst_store u_store (
    .clk_i (clk_i),
    .req_i (st_req),
    .rsp_o (st_rsp)
  );

endmodule

`default_nettype wire
